### design/quaternion_multiply_normalize_macros.svh
// Assertion macros used by the checker of this block.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define QMN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define QMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/qmn_pkg.sv
`default_nettype none
package qmn_pkg;

   // Fraction bits of the input and output components.
   localparam int FRAC_BITS = 14;

   // Widths along the datapath.
   localparam int DW   = 16;              // component width
   localparam int RW   = 15;              // scalar result width
   localparam int NL   = 4;               // components per quaternion
   localparam int PRW  = 2 * DW;          // partial product
   localparam int PW   = PRW + 2;         // signed sum of four products
   localparam int MW   = PW - 1;          // magnitude of that sum
   localparam int QW   = 31;              // normalized magnitude
   localparam int TOP  = QW - 1;          // target position of the leading one
   localparam int SQW  = 2 * QW;          // square of a normalized magnitude
   localparam int SW   = 64;              // sum of squares
   localparam int NW   = SW / 2;          // integer square root
   localparam int QB   = FRAC_BITS + 2;   // quotient bits
   localparam int NUMW = FRAC_BITS + NW;  // rounded dividend
   localparam int WW   = NW + QB;         // divider working register
   localparam int GW   = 8;               // leading-one group width
   localparam int LZG  = 5;               // groups covering the magnitude
   localparam int LZW  = LZG * GW;
   localparam int GPW  = 3;
   localparam int TW   = 6;
   localparam int LSW  = 5;
   localparam int RSW  = 2;

   // Saturation limits, compared against a zero-extended quotient.
   localparam logic [31:0] SAT_POS = 32'd32767;
   localparam logic [31:0] SAT_NEG = 32'd32768;

   typedef logic signed [PRW-1:0] prod_type;
   typedef logic signed [PW-1:0]  p_type;
   typedef logic [QW-1:0]         q_type;
   typedef logic [SQW-1:0]        sq_type;
   typedef logic [SW-1:0]         s_type;
   typedef logic [NUMW-1:0]       num_type;
   typedef logic [WW-1:0]         work_type;
   typedef logic [LZW-1:0]        lzw_type;
   typedef logic [GPW-1:0]        gpos_type;
   typedef logic [TW-1:0]         t_type;
   typedef logic [LSW-1:0]        lsh_type;
   typedef logic [RSW-1:0]        rsh_type;
   typedef logic [31:0]           u32_type;

   typedef struct packed {
      logic signed [DW-1:0] a_x;
      logic signed [DW-1:0] a_y;
      logic signed [DW-1:0] a_z;
      logic signed [DW-1:0] a_w;
      logic signed [DW-1:0] b_x;
      logic signed [DW-1:0] b_y;
      logic signed [DW-1:0] b_z;
      logic signed [DW-1:0] b_w;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] r_x;
      logic signed [DW-1:0] r_y;
      logic signed [DW-1:0] r_z;
      logic [RW-1:0]        r_w;
      logic                 zero_norm;
   } rsp_type;

   // Product magnitudes with their signs.
   typedef struct packed {
      logic [NL-1:0][MW-1:0] mag;
      logic [NL-1:0]         neg;
      logic                  flip;
   } mag_type;

   // Normalized magnitudes and the sign information carried to the end.
   typedef struct packed {
      logic [NL-1:0][QW-1:0] q;
      logic [NL-1:0]         neg;
      logic                  flip;
      logic                  zero;
   } pay_type;

   typedef struct packed {
      pay_type     pay;
      logic [SW-1:0] s;
   } norm_type;

   typedef struct packed {
      pay_type     pay;
      logic [NW-1:0] n;
   } root_type;

endpackage
`default_nettype wire

### design/qmn_mult.sv
`default_nettype none
module qmn_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qmn_pkg::req_type  in_data,
   output logic              in_hold,
   output logic              out_valid,
   output qmn_pkg::mag_type  out_data,
   input  logic              out_hold
);

   logic signed [qmn_pkg::DW-1:0] a_v [qmn_pkg::NL];
   logic signed [qmn_pkg::DW-1:0] b_v [qmn_pkg::NL];
   qmn_pkg::prod_type prod_in [qmn_pkg::NL*qmn_pkg::NL];
   qmn_pkg::prod_type prod_ff [qmn_pkg::NL*qmn_pkg::NL];
   qmn_pkg::p_type    p_v     [qmn_pkg::NL];
   qmn_pkg::p_type    abs_v   [qmn_pkg::NL];
   qmn_pkg::mag_type  s2_in;
   qmn_pkg::mag_type  s2_ff;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic hold1;
   logic hold2;

   // A stage holds only when it is full and the next one holds.
   assign hold2   = s2_valid_ff & out_hold;
   assign hold1   = s1_valid_ff & hold2;
   assign in_hold = hold1;

   assign a_v[0] = in_data.a_x;
   assign a_v[1] = in_data.a_y;
   assign a_v[2] = in_data.a_z;
   assign a_v[3] = in_data.a_w;
   assign b_v[0] = in_data.b_x;
   assign b_v[1] = in_data.b_y;
   assign b_v[2] = in_data.b_z;
   assign b_v[3] = in_data.b_w;

   // All sixteen cross products, entry i*4+j is a[i]*b[j].
   always_comb begin
      for (int i = 0; i < qmn_pkg::NL; i++) begin
         for (int j = 0; j < qmn_pkg::NL; j++) begin
            prod_in[i*qmn_pkg::NL+j] = a_v[i] * b_v[j];
         end
      end
   end

   // Signed sums for the product, then magnitudes and signs.
   always_comb begin
      p_v[0] = qmn_pkg::p_type'(prod_ff[3]) + qmn_pkg::p_type'(prod_ff[6])
             - qmn_pkg::p_type'(prod_ff[9]) + qmn_pkg::p_type'(prod_ff[12]);
      p_v[1] = qmn_pkg::p_type'(prod_ff[7]) - qmn_pkg::p_type'(prod_ff[2])
             + qmn_pkg::p_type'(prod_ff[8]) + qmn_pkg::p_type'(prod_ff[13]);
      p_v[2] = qmn_pkg::p_type'(prod_ff[1]) - qmn_pkg::p_type'(prod_ff[4])
             + qmn_pkg::p_type'(prod_ff[11]) + qmn_pkg::p_type'(prod_ff[14]);
      p_v[3] = qmn_pkg::p_type'(prod_ff[15]) - qmn_pkg::p_type'(prod_ff[0])
             - qmn_pkg::p_type'(prod_ff[5]) - qmn_pkg::p_type'(prod_ff[10]);
      for (int i = 0; i < qmn_pkg::NL; i++) begin
         abs_v[i]       = p_v[i][qmn_pkg::PW-1] ? -p_v[i] : p_v[i];
         s2_in.mag[i]   = abs_v[i][qmn_pkg::MW-1:0];
         s2_in.neg[i]   = p_v[i][qmn_pkg::PW-1];
      end
      s2_in.flip = p_v[3][qmn_pkg::PW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (!hold1) s1_valid_ff <= in_valid;
         if (!hold2) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) prod_ff <= prod_in;
      if (!hold2) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule
`default_nettype wire

### design/qmn_norm.sv
`default_nettype none
module qmn_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qmn_pkg::mag_type   in_data,
   output logic               in_hold,
   output logic               out_valid,
   output qmn_pkg::norm_type  out_data,
   input  logic               out_hold
);

   logic [qmn_pkg::MW-1:0] m01;
   logic [qmn_pkg::MW-1:0] m23;
   logic [qmn_pkg::MW-1:0] max_in;
   logic [qmn_pkg::MW-1:0] c_max_ff;
   qmn_pkg::mag_type       c_data_ff;

   qmn_pkg::lzw_type       padded;
   logic [qmn_pkg::LZG-1:0] nz_in;
   qmn_pkg::gpos_type      pos_in [qmn_pkg::LZG];
   logic [qmn_pkg::LZG-1:0] d1_nz_ff;
   qmn_pkg::gpos_type      d1_pos_ff [qmn_pkg::LZG];
   logic                   d1_zero_ff;
   qmn_pkg::mag_type       d1_data_ff;

   qmn_pkg::t_type         lead;
   qmn_pkg::lsh_type       lsh_in;
   qmn_pkg::rsh_type       rsh_in;
   qmn_pkg::lsh_type       d2_lsh_ff;
   qmn_pkg::rsh_type       d2_rsh_ff;
   logic                   d2_zero_ff;
   qmn_pkg::mag_type       d2_data_ff;

   qmn_pkg::pay_type       e_in;
   qmn_pkg::pay_type       e_ff;
   qmn_pkg::sq_type        sq_in [qmn_pkg::NL];
   qmn_pkg::sq_type        f_sq_ff [qmn_pkg::NL];
   qmn_pkg::pay_type       f_pay_ff;
   qmn_pkg::norm_type      g_in;
   qmn_pkg::norm_type      g_ff;

   logic c_valid_ff, d1_valid_ff, d2_valid_ff, e_valid_ff, f_valid_ff, g_valid_ff;
   logic hold_c, hold_d1, hold_d2, hold_e, hold_f, hold_g;

   assign hold_g  = g_valid_ff & out_hold;
   assign hold_f  = f_valid_ff & hold_g;
   assign hold_e  = e_valid_ff & hold_f;
   assign hold_d2 = d2_valid_ff & hold_e;
   assign hold_d1 = d1_valid_ff & hold_d2;
   assign hold_c  = c_valid_ff & hold_d1;
   assign in_hold = hold_c;

   // Largest of the four magnitudes.
   always_comb begin
      m01    = (in_data.mag[0] > in_data.mag[1]) ? in_data.mag[0] : in_data.mag[1];
      m23    = (in_data.mag[2] > in_data.mag[3]) ? in_data.mag[2] : in_data.mag[3];
      max_in = (m01 > m23) ? m01 : m23;
   end

   // Leading one within each byte of the maximum.
   always_comb begin
      padded = qmn_pkg::lzw_type'(c_max_ff);
      for (int g = 0; g < qmn_pkg::LZG; g++) begin
         nz_in[g]  = |padded[g*qmn_pkg::GW +: qmn_pkg::GW];
         pos_in[g] = '0;
         for (int b = 0; b < qmn_pkg::GW; b++) begin
            if (padded[g*qmn_pkg::GW+b]) pos_in[g] = qmn_pkg::gpos_type'(b);
         end
      end
   end

   // Highest nonzero byte gives the leading one, which sets the common shift.
   always_comb begin
      lead = '0;
      for (int g = 0; g < qmn_pkg::LZG; g++) begin
         if (d1_nz_ff[g]) begin
            lead = qmn_pkg::t_type'(g*qmn_pkg::GW) + qmn_pkg::t_type'(d1_pos_ff[g]);
         end
      end
      if (lead > qmn_pkg::t_type'(qmn_pkg::TOP)) begin
         rsh_in = qmn_pkg::rsh_type'(lead - qmn_pkg::t_type'(qmn_pkg::TOP));
         lsh_in = '0;
      end else begin
         rsh_in = '0;
         lsh_in = qmn_pkg::lsh_type'(qmn_pkg::t_type'(qmn_pkg::TOP) - lead);
      end
   end

   // Common shift puts the largest magnitude just below bit 31.
   always_comb begin
      for (int i = 0; i < qmn_pkg::NL; i++) begin
         if (d2_rsh_ff != '0) begin
            e_in.q[i] = qmn_pkg::q_type'(d2_data_ff.mag[i] >> d2_rsh_ff);
         end else begin
            e_in.q[i] = qmn_pkg::q_type'(d2_data_ff.mag[i] << d2_lsh_ff);
         end
      end
      e_in.neg  = d2_data_ff.neg;
      e_in.flip = d2_data_ff.flip;
      e_in.zero = d2_zero_ff;
   end

   always_comb begin
      for (int i = 0; i < qmn_pkg::NL; i++) begin
         sq_in[i] = qmn_pkg::sq_type'(e_ff.q[i]) * qmn_pkg::sq_type'(e_ff.q[i]);
      end
   end

   always_comb begin
      g_in.pay = f_pay_ff;
      g_in.s   = qmn_pkg::s_type'(f_sq_ff[0]) + qmn_pkg::s_type'(f_sq_ff[1])
               + qmn_pkg::s_type'(f_sq_ff[2]) + qmn_pkg::s_type'(f_sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff  <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         e_valid_ff  <= 1'b0;
         f_valid_ff  <= 1'b0;
         g_valid_ff  <= 1'b0;
      end else begin
         if (!hold_c)  c_valid_ff  <= in_valid;
         if (!hold_d1) d1_valid_ff <= c_valid_ff;
         if (!hold_d2) d2_valid_ff <= d1_valid_ff;
         if (!hold_e)  e_valid_ff  <= d2_valid_ff;
         if (!hold_f)  f_valid_ff  <= e_valid_ff;
         if (!hold_g)  g_valid_ff  <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_c) begin
         c_max_ff  <= max_in;
         c_data_ff <= in_data;
      end
      if (!hold_d1) begin
         d1_nz_ff   <= nz_in;
         d1_pos_ff  <= pos_in;
         d1_zero_ff <= (c_max_ff == '0);
         d1_data_ff <= c_data_ff;
      end
      if (!hold_d2) begin
         d2_lsh_ff  <= lsh_in;
         d2_rsh_ff  <= rsh_in;
         d2_zero_ff <= d1_zero_ff;
         d2_data_ff <= d1_data_ff;
      end
      if (!hold_e) e_ff <= e_in;
      if (!hold_f) begin
         f_sq_ff  <= sq_in;
         f_pay_ff <= e_ff;
      end
      if (!hold_g) g_ff <= g_in;
   end

   assign out_valid = g_valid_ff;
   assign out_data  = g_ff;

endmodule
`default_nettype wire

### design/qmn_sqrt.sv
`default_nettype none
module qmn_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qmn_pkg::norm_type  in_data,
   output logic               in_hold,
   output logic               out_valid,
   output qmn_pkg::root_type  out_data,
   input  logic               out_hold
);

   logic              v_ff   [qmn_pkg::NW];
   qmn_pkg::s_type    x_ff   [qmn_pkg::NW];
   qmn_pkg::s_type    res_ff [qmn_pkg::NW];
   qmn_pkg::pay_type  pay_ff [qmn_pkg::NW];
   logic [qmn_pkg::NW:0] hold;

   assign hold[qmn_pkg::NW] = out_hold;
   assign in_hold = hold[0];

   // One result bit per stage, working down from the top bit pair.
   for (genvar k = 0; k < qmn_pkg::NW; k++) begin : g_step
      localparam qmn_pkg::s_type STEP_BIT = qmn_pkg::s_type'(1) << (qmn_pkg::SW - 2 - 2*k);
      qmn_pkg::s_type   src_x;
      qmn_pkg::s_type   src_res;
      qmn_pkg::pay_type src_pay;
      logic             src_v;
      qmn_pkg::s_type   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign src_x   = in_data.s;
         assign src_res = '0;
         assign src_pay = in_data.pay;
         assign src_v   = in_valid;
      end else begin : g_next
         assign src_x   = x_ff[k-1];
         assign src_res = res_ff[k-1];
         assign src_pay = pay_ff[k-1];
         assign src_v   = v_ff[k-1];
      end

      assign hold[k] = v_ff[k] & hold[k+1];
      assign trial   = src_res + STEP_BIT;
      assign ge      = (src_x >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (!hold[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[k]) begin
            x_ff[k]   <= ge ? (src_x - trial) : src_x;
            res_ff[k] <= ge ? ((src_res >> 1) + STEP_BIT) : (src_res >> 1);
            pay_ff[k] <= src_pay;
         end
      end
   end

   assign out_valid    = v_ff[qmn_pkg::NW-1];
   assign out_data.pay = pay_ff[qmn_pkg::NW-1];
   assign out_data.n   = res_ff[qmn_pkg::NW-1][qmn_pkg::NW-1:0];

endmodule
`default_nettype wire

### design/qmn_div.sv
`default_nettype none
module qmn_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qmn_pkg::root_type  in_data,
   output logic               in_hold,
   output logic               out_valid,
   output qmn_pkg::rsp_type   out_data,
   input  logic               out_hold
);

   typedef struct packed {
      logic [qmn_pkg::NW-1:0] n;
      logic [qmn_pkg::NL-1:0] neg;
      logic                   flip;
      logic                   zero;
   } side_type;

   typedef logic [qmn_pkg::NL-1:0][qmn_pkg::WW-1:0] lanes_type;

   logic       v_ff    [qmn_pkg::QB+1];
   lanes_type  work_ff [qmn_pkg::QB+1];
   side_type   side_ff [qmn_pkg::QB+1];
   logic [qmn_pkg::QB+1:0] hold;
   lanes_type  work0_in;
   side_type   side0_in;
   qmn_pkg::num_type num_v;

   qmn_pkg::rsp_type rsp_in;
   qmn_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic [qmn_pkg::DW-1:0] vec_v [3];
   qmn_pkg::u32_type quo;
   qmn_pkg::u32_type quo_neg;
   logic             res_neg;
   logic [qmn_pkg::RW-1:0] w_v;

   assign hold[qmn_pkg::QB+1] = rsp_valid_ff & out_hold;
   assign in_hold = hold[0];

   // Rounded dividend: magnitude scaled by the fraction, plus half the norm.
   always_comb begin
      work0_in = '0;
      for (int i = 0; i < qmn_pkg::NL; i++) begin
         num_v = qmn_pkg::num_type'({in_data.pay.q[i], {qmn_pkg::FRAC_BITS{1'b0}}})
               + qmn_pkg::num_type'(in_data.n >> 1);
         work0_in[i] = qmn_pkg::work_type'(num_v);
      end
      side0_in.n    = in_data.n;
      side0_in.neg  = in_data.pay.neg;
      side0_in.flip = in_data.pay.flip;
      side0_in.zero = in_data.pay.zero;
   end

   assign hold[0] = v_ff[0] & hold[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (!hold[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         work_ff[0] <= work0_in;
         side_ff[0] <= side0_in;
      end
   end

   // Restoring division, one quotient bit per stage in each of the four lanes.
   for (genvar k = 1; k <= qmn_pkg::QB; k++) begin : g_step
      lanes_type work_in;

      always_comb begin
         logic [qmn_pkg::WW:0]   sh;
         logic [qmn_pkg::NW:0]   top;
         logic [qmn_pkg::NW:0]   diff;
         logic                   ge;
         for (int i = 0; i < qmn_pkg::NL; i++) begin
            sh   = {work_ff[k-1][i], 1'b0};
            top  = sh[qmn_pkg::WW:qmn_pkg::QB];
            diff = top - {1'b0, side_ff[k-1].n};
            ge   = (top >= {1'b0, side_ff[k-1].n});
            work_in[i] = {ge ? diff[qmn_pkg::NW-1:0] : top[qmn_pkg::NW-1:0],
                          sh[qmn_pkg::QB-1:1], ge};
         end
      end

      assign hold[k] = v_ff[k] & hold[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (!hold[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[k]) begin
            work_ff[k] <= work_in;
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Sign, saturation and the all-zero case.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo     = qmn_pkg::u32_type'(work_ff[qmn_pkg::QB][i][qmn_pkg::QB-1:0]);
         quo_neg = ~quo + 32'd1;
         res_neg = side_ff[qmn_pkg::QB].neg[i] ^ side_ff[qmn_pkg::QB].flip;
         if (res_neg) begin
            vec_v[i] = (quo > qmn_pkg::SAT_NEG) ? qmn_pkg::SAT_NEG[qmn_pkg::DW-1:0]
                                                : quo_neg[qmn_pkg::DW-1:0];
         end else begin
            vec_v[i] = (quo > qmn_pkg::SAT_POS) ? qmn_pkg::SAT_POS[qmn_pkg::DW-1:0]
                                                : quo[qmn_pkg::DW-1:0];
         end
      end
      quo     = qmn_pkg::u32_type'(work_ff[qmn_pkg::QB][3][qmn_pkg::QB-1:0]);
      quo_neg = '0;
      res_neg = side_ff[qmn_pkg::QB].neg[3] ^ side_ff[qmn_pkg::QB].flip;
      if (res_neg) begin
         w_v = '0;
      end else begin
         w_v = (quo > qmn_pkg::SAT_POS) ? qmn_pkg::SAT_POS[qmn_pkg::RW-1:0]
                                        : quo[qmn_pkg::RW-1:0];
      end
      if (side_ff[qmn_pkg::QB].zero) begin
         rsp_in = '0;
         rsp_in.zero_norm = 1'b1;
      end else begin
         rsp_in.r_x       = vec_v[0];
         rsp_in.r_y       = vec_v[1];
         rsp_in.r_z       = vec_v[2];
         rsp_in.r_w       = w_v;
         rsp_in.zero_norm = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold[qmn_pkg::QB+1]) begin
         rsp_valid_ff <= v_ff[qmn_pkg::QB];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[qmn_pkg::QB+1]) rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule
`default_nettype wire

### design/quaternion_multiply_normalize.sv
`default_nettype none
// Multiplies two Q1.14 quaternions (x, y, z, then scalar w) and returns the
// product divided by its Euclidean norm, rounded to nearest, with the scalar
// part made non-negative by negating all four components when needed. An
// all-zero product returns zeros with zero_norm set. The block takes one
// transaction per clock while req_stall is low. Each accepted transaction
// passes through the products and sums, normalization and squaring, the
// square root (one result bit per stage), and the divider (the rounded
// dividend register, 16 stages of one quotient bit each in four lanes,
// and its output register). A stall only freezes stages that hold
// data, so empty stages keep taking transactions.
module quaternion_multiply_normalize (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qmn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qmn_pkg::rsp_type  rsp_data
);

   qmn_pkg::mag_type  mag_data;
   qmn_pkg::norm_type norm_data;
   qmn_pkg::root_type root_data;
   logic mag_valid, norm_valid, root_valid;
   logic mag_hold, norm_hold, root_hold;

   // Cross products and signed sums.
   qmn_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_hold   (req_stall),
      .out_valid (mag_valid),
      .out_data  (mag_data),
      .out_hold  (mag_hold)
   );

   // Common normalization shift and sum of squares.
   qmn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_data   (mag_data),
      .in_hold   (mag_hold),
      .out_valid (norm_valid),
      .out_data  (norm_data),
      .out_hold  (norm_hold)
   );

   // Integer square root of the sum of squares.
   qmn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_data   (norm_data),
      .in_hold   (norm_hold),
      .out_valid (root_valid),
      .out_data  (root_data),
      .out_hold  (root_hold)
   );

   // Division by the norm and output formatting.
   qmn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .in_hold   (root_hold),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_hold  (rsp_stall)
   );

endmodule
`default_nettype wire

### design/qmn_checker.sv
`default_nettype none
`include "quaternion_multiply_normalize_macros.svh"
module qmn_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qmn_pkg::rsp_type  rsp_data
);

   // A stalled result transaction stays offered and unchanged.
   `QMN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // With the output empty no stage can be held, so input is never stalled.
   `QMN_ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "input stalled with empty output")

   // A zero-norm result carries all-zero components.
   `QMN_ASSERT_SAME(a_zero_fields, clock, reset, rsp_valid && rsp_data.zero_norm, rsp_data.r_x == 0 && rsp_data.r_y == 0 && rsp_data.r_z == 0 && rsp_data.r_w == 0, "zero-norm result not zero")

   // A normalized nonzero product always has a nonzero component.
   `QMN_ASSERT_SAME(a_unit_nonzero, clock, reset, rsp_valid && !rsp_data.zero_norm, rsp_data.r_x != 0 || rsp_data.r_y != 0 || rsp_data.r_z != 0 || rsp_data.r_w != 0, "normalized result is all zero")

endmodule

bind quaternion_multiply_normalize qmn_checker u_checker (.*);
`default_nettype wire

### tb/tb_quaternion_multiply_normalize.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_quaternion_multiply_normalize;

   // Scoreboard that predicts the normalized product and checks each result.
   class quat_scoreboard;
      qmn_pkg::rsp_type expected_q[$];
      int      mismatches;

      static function automatic longint unsigned sqrt_floor(longint unsigned x);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x   = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // Forms the product, normalizes it and makes the scalar part non-negative.
      static function automatic qmn_pkg::rsp_type normalized_product(qmn_pkg::req_type r);
         longint          ax, ay, az, aw, bx, by, bz, bw;
         longint          p[4];
         longint unsigned mag[4];
         longint unsigned mx, s, n, half, q;
         longint          v;
         int              sh;
         bit              flip, neg;
         qmn_pkg::rsp_type o;
         ax = r.a_x; ay = r.a_y; az = r.a_z; aw = r.a_w;
         bx = r.b_x; by = r.b_y; bz = r.b_z; bw = r.b_w;
         p[0] =  ax * bw + ay * bz - az * by + aw * bx;
         p[1] = -ax * bz + ay * bw + az * bx + aw * by;
         p[2] =  ax * by - ay * bx + az * bw + aw * bz;
         p[3] = -ax * bx - ay * by - az * bz + aw * bw;
         mx = 0;
         for (int i = 0; i < 4; i++) begin
            mag[i] = (p[i] < 0) ? -p[i] : p[i];
            if (mag[i] > mx) mx = mag[i];
         end
         o = '0;
         if (mx == 0) begin
            o.zero_norm = 1'b1;
            return o;
         end
         sh = 0;
         while (mx >= (64'd1 << 31)) begin mx >>= 1; sh--; end
         while (mx < (64'd1 << 30)) begin mx <<= 1; sh++; end
         s = 0;
         for (int i = 0; i < 4; i++) begin
            if (sh >= 0) mag[i] = mag[i] << sh;
            else mag[i] = mag[i] >> (-sh);
            s += mag[i] * mag[i];
         end
         n    = sqrt_floor(s);
         half = n >> 1;
         flip = p[3] < 0;
         for (int i = 0; i < 4; i++) begin
            q   = ((mag[i] << qmn_pkg::FRAC_BITS) + half) / n;
            neg = (p[i] < 0) != flip;
            v   = neg ? -longint'(q) : longint'(q);
            if (v > 32767) v = 32767;
            if (i < 3) begin
               if (v < -32768) v = -32768;
            end else if (v < 0) begin
               v = 0;
            end
            case (i)
               0: o.r_x = v[15:0];
               1: o.r_y = v[15:0];
               2: o.r_z = v[15:0];
               default: o.r_w = v[14:0];
            endcase
         end
         return o;
      endfunction

      function void note_request(qmn_pkg::req_type r);
         expected_q.push_back(normalized_product(r));
      endfunction

      function void check_result(qmn_pkg::rsp_type got);
         qmn_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = expected_q.pop_front();
         if (got.r_x !== want.r_x || got.r_y !== want.r_y || got.r_z !== want.r_z ||
             got.r_w !== want.r_w || got.zero_norm !== want.zero_norm) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d zn=%0b, got x=%0d y=%0d z=%0d w=%0d zn=%0b",
                  want.r_x, want.r_y, want.r_z, want.r_w, want.zero_norm,
                  got.r_x, got.r_y, got.r_z, got.r_w, got.zero_norm);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   qmn_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   qmn_pkg::rsp_type rsp_data;

   quat_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;
   longint cycle_count = 0;

   quaternion_multiply_normalize DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) board.check_result(rsp_data);
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb_quaternion_multiply_normalize: FAIL");
         $finish;
      end
   end

   // Offers one transaction, idling first at random, and waits for acceptance.
   task automatic send_transaction(qmn_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   function automatic logic [15:0] random_component();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh4000;
         3: return 16'shc000;
         4: return 16'h0000;
         5: return 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic qmn_pkg::req_type random_request();
      qmn_pkg::req_type r;
      r = {random_component(), random_component(), random_component(), random_component(),
           random_component(), random_component(), random_component(), random_component()};
      // Occasionally zero one whole quaternion to reach the zero-norm case.
      if ($urandom_range(19) == 0) r[127:64] = '0;
      return r;
   endfunction

   qmn_pkg::req_type directed[$];

   initial begin
      qmn_pkg::req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero product, identities, extremes, negative scalar, zero scalar.
      directed.push_back('0);
      r = '0; r.a_w = 16'sh4000; r.b_x = 16'sh1234; directed.push_back(r);
      r = '0; r.a_w = 16'sh4000; r.b_w = 16'sh4000; directed.push_back(r);
      r = '0; r.a_w = 16'shc000; r.b_w = 16'sh4000; directed.push_back(r);
      r = '0; r.a_x = 16'sh4000; r.b_y = 16'sh4000; directed.push_back(r);
      r = '0; r.a_x = 16'sh4000; r.b_x = 16'sh4000; directed.push_back(r);
      r = {8{16'sh8000}}; directed.push_back(r);
      r = {8{16'sh7fff}}; directed.push_back(r);
      r = {{7{16'sh8000}}, 16'sh7fff}; directed.push_back(r);
      r = {16'sh0001, 48'h0, 16'sh0001, 48'h0}; directed.push_back(r);
      r = {64'h0, 16'shffff, 16'sh0001, 16'shffff, 16'sh7fff}; directed.push_back(r);
      r = {16'sh8000, 16'sh7fff, 16'shffff, 16'sh0000,
           16'sh5555, 16'shaaaa, 16'sh0001, 16'sh8000}; directed.push_back(r);
      foreach (directed[i]) send_transaction(directed[i]);

      // Random phases with different idling.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            3: begin send_idle_pct = 27; recv_stall_pct = 27; end
            default: begin
               send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 300;
            end
         endcase
         repeat (120) send_transaction(random_request());
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("tb_quaternion_multiply_normalize: PASS");
      end else begin
         $display("tb_quaternion_multiply_normalize: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
